>>> rtl/frt_pkg.sv
package frt_pkg;

    // Field and register widths.
    localparam int ID_W     = 16;
    localparam int RADIX_W  = 7;
    localparam int LEVELS_W = 4;
    localparam int LEVEL_W  = 3;
    localparam int COUNT_W  = 17;
    localparam int PTR_W    = 6;
    localparam int DIR_W    = 7;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_RADIX = 64;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS = ID_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MY_LEVEL         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MY_SWITCH        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEAF         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVES_REACHABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVES_PER_PATH  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the input word and make the route decision
        logic div_step;  // run one divider step
        logic load_out;  // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // the decision just made is a down route
        logic out_free;  // the output register can take a word this cycle
    } t_sts;

endpackage

>>> rtl/frt_ctrl.sv
module frt_ctrl
    import frt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A down route detours through the divider before finishing.
        if (o_cmd.accept && i_sts.need_div) begin
            n_state = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/frt_dpath.sv
module frt_dpath
    import frt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [ID_W-1:0]      i_dest_switch,
    input  logic                 i_out_stall,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic                 o_go_down,
    output logic [DIR_W-1:0]     o_direction,
    output logic                 o_vchan,
    output logic [RADIX_W-1:0]   o_path_count
);

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic logic [COUNT_W:0] div_bit(
        input logic [COUNT_W-1:0] rem,
        input logic               din,
        input logic [COUNT_W-1:0] dvs
    );
        logic [COUNT_W:0] sh;
        logic [COUNT_W:0] diff;
        logic             fits;
        sh   = {rem, din};
        diff = sh - {1'b0, dvs};
        fits = (sh >= {1'b0, dvs});
        div_bit = fits ? {diff[COUNT_W-1:0], 1'b1} : {sh[COUNT_W-1:0], 1'b0};
    endfunction

    // Configuration registers.
    logic [RADIX_W-1:0]  r_radix;
    logic [LEVELS_W-1:0] r_tree_levels;
    logic [LEVEL_W-1:0]  r_my_level;
    logic [ID_W-1:0]     r_my_switch;
    logic [ID_W-1:0]     r_min_leaf;
    logic [COUNT_W-1:0]  r_leaves_reachable;
    logic [COUNT_W-1:0]  r_leaves_per_path;

    // Routing state.
    logic [PTR_W-1:0]    r_up_ptr;
    logic                r_down_role;

    // Decision held while the divider runs.
    logic                r_down;
    logic [PTR_W-1:0]    r_port;
    logic [DIR_W-1:0]    r_role_add;
    logic [RADIX_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_rem;
    logic [ID_W-1:0]     r_quo;
    logic [COUNT_W-1:0]  r_dvs;

    // Output register.
    logic                r_out_valid;
    logic                r_out_down;
    logic [DIR_W-1:0]    r_out_dir;
    logic [RADIX_W-1:0]  r_out_count;

    logic                top;
    logic                lvl0;
    logic                in_range;
    logic                down;
    logic [COUNT_W:0]    range_end;
    logic [RADIX_W-1:0]  count;
    logic [RADIX_W-1:0]  ptr_inc;
    logic [PTR_W-1:0]    n_up_ptr;
    logic [ID_W-1:0]     rel;
    logic [COUNT_W:0]    step_a;
    logic [COUNT_W:0]    step_b;
    logic [DIR_W-1:0]    dir;

    always_comb begin
        lvl0      = (r_my_level == '0);
        top       = (r_tree_levels != '0) &&
                    ({1'b0, r_my_level} == (r_tree_levels - 1'b1));
        range_end = {2'b00, r_min_leaf} + {1'b0, r_leaves_reachable};
        in_range  = (i_dest_switch >= r_min_leaf) &&
                    ({2'b00, i_dest_switch} < range_end);
        down      = !lvl0 && (top || in_range);

        if (i_dest_switch == r_my_switch) begin
            count = RADIX_W'(1);
        end else if (lvl0) begin
            count = r_radix;
        end else if (top) begin
            count = RADIX_W'(2);
        end else if (in_range) begin
            count = RADIX_W'(1);
        end else begin
            count = r_radix;
        end

        ptr_inc = {1'b0, r_up_ptr} + 1'b1;
        if ((ptr_inc >= r_radix) || (ptr_inc >= RADIX_W'(MAX_RADIX))) begin
            n_up_ptr = '0;
        end else begin
            n_up_ptr = ptr_inc[PTR_W-1:0];
        end

        rel = i_dest_switch - r_min_leaf;

        step_a = div_bit(r_rem, r_quo[ID_W-1], r_dvs);
        step_b = div_bit(step_a[COUNT_W:1], r_quo[ID_W-2], r_dvs);

        if (r_down) begin
            dir = r_quo[DIR_W-1:0] + r_role_add;
        end else begin
            dir = {1'b0, r_port};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix            <= RADIX_W'(2);
            r_tree_levels      <= LEVELS_W'(1);
            r_my_level         <= '0;
            r_my_switch        <= '0;
            r_min_leaf         <= '0;
            r_leaves_reachable <= COUNT_W'(1);
            r_leaves_per_path  <= COUNT_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_RADIX:            r_radix            <= i_cfg_data[RADIX_W-1:0];
                REG_TREE_LEVELS:      r_tree_levels      <= i_cfg_data[LEVELS_W-1:0];
                REG_MY_LEVEL:         r_my_level         <= i_cfg_data[LEVEL_W-1:0];
                REG_MY_SWITCH:        r_my_switch        <= i_cfg_data[ID_W-1:0];
                REG_MIN_LEAF:         r_min_leaf         <= i_cfg_data[ID_W-1:0];
                REG_LEAVES_REACHABLE: r_leaves_reachable <= i_cfg_data[COUNT_W-1:0];
                REG_LEAVES_PER_PATH:  r_leaves_per_path  <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_ptr    <= '0;
            r_down_role <= 1'b0;
        end else if (i_cmd.accept) begin
            if (!down) begin
                r_up_ptr <= n_up_ptr;
            end
            if (!lvl0 && top) begin
                r_down_role <= !r_down_role;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_down     <= down;
            r_port     <= r_up_ptr;
            r_role_add <= (top && r_down_role) ? r_radix : '0;
            r_count    <= count;
            r_rem      <= '0;
            r_quo      <= rel;
            r_dvs      <= (r_leaves_per_path == '0) ? COUNT_W'(1) : r_leaves_per_path;
        end else if (i_cmd.div_step) begin
            r_rem <= step_b[COUNT_W:1];
            r_quo <= {r_quo[ID_W-3:0], step_a[0], step_b[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_down  <= r_down;
            r_out_dir   <= dir;
            r_out_count <= r_count;
        end
    end

    assign o_sts.need_div = down;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_go_down    = r_out_down;
    assign o_direction  = r_out_dir;
    assign o_vchan      = r_out_down;
    assign o_path_count = r_out_count;

endmodule

>>> rtl/fat_tree_route_select_unit.sv
// An input word taken for an up route goes through the done state into the output register;
// a down route first passes through the divide state, in a divider retiring two bits a cycle.
// A new word is taken only once the last one sits in the output register, so the block does
// not take a new word while it is still busy with the last; a waiting result delays the next
// only while it is still stalled. Reset is synchronous and active low; it restores the
// register defaults and clears the pointer, the role bit and the valid.
module fat_tree_route_select_unit
    import frt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // Input channel: one destination word per packet.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ID_W-1:0]      i_dest_switch,

    // Output channel: one route word per packet.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_go_down,
    output logic [DIR_W-1:0]     o_direction,
    output logic                 o_vchan,
    output logic [RADIX_W-1:0]   o_path_count
);

    // The controller sequences accept, divide and hand-off; the datapath holds
    // the registers, the route decision, the divider and the output register.
    t_cmd cmd;
    t_sts sts;

    frt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    frt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_dest_switch (i_dest_switch),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_go_down     (o_go_down),
        .o_direction   (o_direction),
        .o_vchan       (o_vchan),
        .o_path_count  (o_path_count)
    );

endmodule

>>> tb/fat_tree_route_select_unit_test.sv
`timescale 1ns / 1ps

module fat_tree_route_select_unit_test;
    import frt_pkg::*;

    // The longest correct stretch with no accepted word is a full register load, the drain
    // pause, the sender's longest gap, a down route through the divider and the receiver's
    // longest stall. The limit lies far beyond that stretch.
    localparam int IDLE_LIMIT   = 2000;
    // The pause after the last route word is back lets the block settle before the registers change.
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_WORDS = 1000;
    localparam int MAX_GAP      = 16;

    // One route word as the block presents it on the output channel.
    typedef struct packed {
        logic               go_down;
        logic [DIR_W-1:0]   direction;
        logic               vchan;
        logic [RADIX_W-1:0] path_count;
    } t_route_word;

    // Keeps a private copy of the switch registers, the round-robin pointer and the
    // top-level role bit. Each accepted destination is turned into the route word that
    // the block must produce, and route words coming out are matched in order.
    class route_tracker;
        logic [RADIX_W-1:0]  radix;
        logic [LEVELS_W-1:0] tree_levels;
        logic [LEVEL_W-1:0]  my_level;
        logic [ID_W-1:0]     my_switch;
        logic [ID_W-1:0]     min_leaf;
        logic [COUNT_W-1:0]  leaves_reach;
        logic [COUNT_W-1:0]  leaves_per_path;
        logic [PTR_W-1:0]    up_ptr;
        logic                down_role;
        t_route_word         pending_routes[$];
        int                  errors;

        function new();
            radix           = RADIX_W'(2);
            tree_levels     = LEVELS_W'(1);
            my_level        = '0;
            my_switch       = '0;
            min_leaf        = '0;
            leaves_reach    = COUNT_W'(1);
            leaves_per_path = COUNT_W'(1);
            up_ptr          = '0;
            down_role       = 1'b0;
            errors          = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RADIX:            radix           = data[RADIX_W-1:0];
                REG_TREE_LEVELS:      tree_levels     = data[LEVELS_W-1:0];
                REG_MY_LEVEL:         my_level        = data[LEVEL_W-1:0];
                REG_MY_SWITCH:        my_switch       = data[ID_W-1:0];
                REG_MIN_LEAF:         min_leaf        = data[ID_W-1:0];
                REG_LEAVES_REACHABLE: leaves_reach    = data[COUNT_W-1:0];
                REG_LEAVES_PER_PATH:  leaves_per_path = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // The pointer wraps at the radix or at the hardware port limit, whichever is hit
        // first, so a radix of 0 or 1 keeps handing out port 0.
        function logic [31:0] next_up_port();
            logic [31:0] port;
            int          nxt;
            port = 32'(up_ptr);
            nxt  = int'(up_ptr) + 1;
            if (nxt >= int'(radix) || nxt >= MAX_RADIX)
                nxt = 0;
            up_ptr = PTR_W'(nxt);
            return port;
        endfunction

        // The offset from min_leaf wraps in the id width, and zero leaves per path acts as one.
        function logic [31:0] down_group(logic [ID_W-1:0] dest);
            logic [ID_W-1:0] rel;
            logic [31:0]     per;
            rel = dest - min_leaf;
            per = (leaves_per_path == 0) ? 32'd1 : 32'(leaves_per_path);
            return 32'(rel) / per;
        endfunction

        function void note_dest(logic [ID_W-1:0] dest);
            t_route_word r;
            logic        top;
            logic        in_range;
            logic [31:0] dir;
            top      = (tree_levels != 0) && (32'(my_level) == 32'(tree_levels) - 32'd1);
            in_range = (dest >= min_leaf) &&
                       (32'(dest) < 32'(min_leaf) + 32'(leaves_reach));
            // Level 0 wins over the top-level test, so a one-level tree routes up.
            if (my_level == 0) begin
                r.go_down = 1'b0;
                dir       = next_up_port();
            end else if (top) begin
                r.go_down = 1'b1;
                dir       = down_group(dest) + (down_role ? 32'(radix) : 32'd0);
                down_role = ~down_role;
            end else if (in_range) begin
                r.go_down = 1'b1;
                dir       = down_group(dest);
            end else begin
                r.go_down = 1'b0;
                dir       = next_up_port();
            end
            r.direction = dir[DIR_W-1:0];
            r.vchan     = r.go_down;
            if (dest == my_switch)
                r.path_count = RADIX_W'(1);
            else if (my_level == 0)
                r.path_count = radix;
            else if (top)
                r.path_count = RADIX_W'(2);
            else if (in_range)
                r.path_count = RADIX_W'(1);
            else
                r.path_count = radix;
            pending_routes = {pending_routes, r};
        endfunction

        function void check_field(string field, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_route(logic go_down, logic [DIR_W-1:0] direction, logic vchan,
                                  logic [RADIX_W-1:0] path_count);
            t_route_word exp_word;
            if (pending_routes.size() == 0) begin
                $display("%0t: route word with none expected: expected nothing, actual %0d/%0d",
                         $time, go_down, direction);
                errors++;
                return;
            end
            exp_word = pending_routes.pop_front();
            check_field("go_down", int'(exp_word.go_down), int'(go_down));
            check_field("direction", int'(exp_word.direction), int'(direction));
            check_field("vchan", int'(exp_word.vchan), int'(vchan));
            check_field("path_count", int'(exp_word.path_count), int'(path_count));
        endfunction

        function int pending();
            return pending_routes.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ID_W-1:0]      i_dest_switch;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_go_down;
    logic [DIR_W-1:0]     o_direction;
    logic                 o_vchan;
    logic [RADIX_W-1:0]   o_path_count;

    // Per-phase switches that turn idling off on either side for a stretch.
    logic                 in_no_idle;
    logic                 out_no_stall;
    int                   idle_cycles;
    route_tracker         routes;

    fat_tree_route_select_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_dest_switch (i_dest_switch),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_go_down     (o_go_down),
        .o_direction   (o_direction),
        .o_vchan       (o_vchan),
        .o_path_count  (o_path_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // One register write per clock edge. The tracker takes the value at the same edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        routes.set_reg(idx, data);
    endtask

    // Loads the whole register set. Only called while no route is in flight.
    task automatic load_settings(int radix, int levels, int level, int sw_id, int low_leaf,
                                 int reach, int per_path);
        write_reg(REG_RADIX, CFG_W'(radix));
        write_reg(REG_TREE_LEVELS, CFG_W'(levels));
        write_reg(REG_MY_LEVEL, CFG_W'(level));
        write_reg(REG_MY_SWITCH, CFG_W'(sw_id));
        write_reg(REG_MIN_LEAF, CFG_W'(low_leaf));
        write_reg(REG_LEAVES_REACHABLE, CFG_W'(reach));
        write_reg(REG_LEAVES_PER_PATH, CFG_W'(per_path));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offers one destination word after a random gap and holds it until it is taken.
    // With no gap the valid stays high straight into the next word.
    task automatic send_dest(logic [ID_W-1:0] dest);
        int gap;
        gap = in_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_dest_switch <= dest;
        do @(posedge i_clk); while (o_in_stall);
        routes.note_dest(dest);
    endtask

    // Drops the input valid and waits until every route word is back, then lets the
    // block settle before the registers may change.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (routes.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Destinations lean toward the reachable range, its edges and the switch's own id,
    // since those steer the decision; the rest are spread over the whole id space.
    function automatic logic [ID_W-1:0] pick_dest();
        int          sel;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] d;
        sel  = $urandom_range(0, 99);
        base = 32'(routes.min_leaf);
        span = 32'(routes.leaves_reach);
        if (sel < 40) begin
            d = base + ((span == 0) ? 32'd0 : ($urandom % span));
        end else if (sel < 50) begin
            d = 32'(routes.my_switch);
        end else if (sel < 65) begin
            case ($urandom_range(0, 3))
                0:       d = base - 1;
                1:       d = base;
                2:       d = base + span - 1;
                default: d = base + span;
            endcase
        end else begin
            d = $urandom_range(0, 65535);
        end
        return d[ID_W-1:0];
    endfunction

    // Draws a switch setting. Leaf, top and middle switches come up about equally often,
    // with now and then a radix or level count outside the usual range.
    task automatic load_random_settings();
        int radix;
        int levels;
        int level;
        int reach;
        int per_path;
        if ($urandom_range(0, 99) < 85) begin
            radix = $urandom_range(2, 64);
        end else begin
            case ($urandom_range(0, 4))
                0:       radix = 0;
                1:       radix = 1;
                2:       radix = 127;
                3:       radix = 64;
                default: radix = 2;
            endcase
        end
        levels = $urandom_range(1, 8);
        if ($urandom_range(0, 19) == 0)
            levels = $urandom_range(0, 1) ? 0 : 15;
        case ($urandom_range(0, 2))
            0:       level = 0;
            1:       level = (levels == 0 || levels > 8) ? 7 : levels - 1;
            default: level = $urandom_range(1, 7);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: reach = $urandom_range(1, 4096);
            5, 6, 7:       reach = $urandom_range(1, 65536);
            default:       reach = $urandom_range(0, 1) ? 65536 : 1;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: per_path = (radix > 1) ? reach / radix : reach;
            5, 6:          per_path = $urandom_range(1, 8);
            7, 8:          per_path = $urandom_range(0, 65536);
            default:       per_path = 0;
        endcase
        if (per_path == 0 && $urandom_range(0, 1))
            per_path = 1;
        load_settings(radix, levels, level, $urandom_range(0, 65535),
                      $urandom_range(0, 65535), reach, per_path);
    endtask

    // Receiver: before each word it stalls for a random number of cycles, then keeps the
    // stall low until a word is taken.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = out_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Output check and watchdog. Both handshakes are sampled at the clock edge, so they
    // see the values from before the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && !i_out_stall)
                routes.check_route(o_go_down, o_direction, o_vchan, o_path_count);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int words;
        int burst;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = REG_RADIX;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_dest_switch = '0;
        in_no_idle    = 1'b0;
        out_no_stall  = 1'b0;
        idle_cycles   = 0;
        routes        = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a leaf switch of radix 2, so up routes alternate between ports.
        // Destination 0 matches the switch's own id.
        send_dest(16'h0000);
        send_dest(16'hFFFF);
        send_dest(16'h0001);
        wait_idle();

        // Middle switch: the range edges go down, the ids just outside go up.
        load_settings(64, 8, 3, 16'h1234, 16'h1000, 17'h00400, 17'h00010);
        send_dest(16'h1000);
        send_dest(16'h13FF);
        send_dest(16'h1400);
        send_dest(16'h0FFF);
        send_dest(16'h1234);
        wait_idle();

        // Top switch with the widest range and the largest groups. The role bit adds the
        // radix on every other word, pushing the direction past 7 bits, and ids below
        // min_leaf wrap around before the division.
        load_settings(64, 4, 3, 16'hFFFF, 16'h8000, 17'h10000, 17'h10000);
        send_dest(16'h8000);
        send_dest(16'hFFFF);
        wait_idle();
        write_reg(REG_LEAVES_PER_PATH, 17'h00200);
        i_cfg_wr_en <= 1'b0;
        wait_idle();
        send_dest(16'h0000);
        send_dest(16'h7FFF);
        send_dest(16'hFFFF);
        wait_idle();

        // A level above the top acts as a middle switch. Zero leaves per path divides by
        // one, and radix 0 keeps the up pointer on port 0.
        load_settings(0, 2, 5, 16'h0000, 16'h0100, 17'h00010, 17'h00000);
        send_dest(16'h0105);
        send_dest(16'h0000);
        send_dest(16'hFFFF);
        wait_idle();

        // One-level tree: level 0 wins, so the switch routes up. Radix 127 is beyond the
        // port limit, radix 1 holds port 0.
        load_settings(127, 1, 0, 16'h5555, 16'h0000, 17'h1FFFF, 17'h1FFFF);
        send_dest(16'hAAAA);
        send_dest(16'h5555);
        wait_idle();
        write_reg(REG_RADIX, 17'd1);
        i_cfg_wr_en <= 1'b0;
        wait_idle();
        send_dest(16'h0F0F);
        send_dest(16'hF0F0);
        wait_idle();

        // No levels at all: no switch counts as top, so level 7 is a middle switch.
        load_settings(5, 0, 7, 16'h0000, 16'h0010, 17'h00020, 17'h00004);
        send_dest(16'h001F);
        send_dest(16'h0030);
        wait_idle();

        // Random phases: a fresh setting, a run of destination words, then a full drain.
        // Some phases turn idling off on one or both sides.
        words = 0;
        while (words < RANDOM_WORDS) begin
            load_random_settings();
            in_no_idle   = ($urandom_range(0, 3) == 0);
            out_no_stall = ($urandom_range(0, 3) == 0);
            burst        = $urandom_range(20, 80);
            repeat (burst) send_dest(pick_dest());
            words += burst;
            wait_idle();
        end

        if (routes.errors == 0 && routes.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/frt_pkg.sv
rtl/frt_ctrl.sv
rtl/frt_dpath.sv
rtl/fat_tree_route_select_unit.sv
tb/fat_tree_route_select_unit_test.sv
